// ===== hdl/pmsu_pkg.sv =====
// Package for the momentum SGD update core with a power-transformed gradient.
// Holds word types, configuration codes, saturation helpers and the exp2 constants.
// Used by every module of the block; depends on nothing.
package pmsu_pkg;

	localparam int ELEMENTS_DEF = 4096;

	localparam logic [15:0] LR_RST    = 16'd655;
	localparam logic [15:0] MF_RST    = 16'd58982;
	localparam logic [15:0] DECAY_RST = 16'd0;
	localparam logic [15:0] EXPO_RST  = 16'd256;

	typedef enum logic [1:0] {
		CFG_LR    = 2'd0,
		CFG_MF    = 2'd1,
		CFG_DECAY = 2'd2,
		CFG_EXPO  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] lr;
		logic [15:0] mf;
		logic [15:0] decay;
		logic [15:0] expo;
	} cfg_t;

	typedef struct packed {
		logic [11:0]        element_index;
		logic signed [31:0] gradient_value;
		logic signed [31:0] param_value;
	} in_t;

	typedef struct packed {
		logic [11:0]        out_index;
		logic signed [31:0] new_param;
		logic               saturated;
	} out_t;

	// Payload that rides along with a word through the pipeline.
	typedef struct packed {
		logic [11:0]        idx;
		logic signed [31:0] p;
		logic               in_rng;
		logic               neg;
		logic               zero;
		logic               sat;
	} side_t;

	function automatic logic signed [31:0] clip_q(input logic signed [33:0] x);
		if (x > 34'sd2147483647)
			return 32'h7FFF_FFFF;
		else if (x < -34'sd2147483648)
			return 32'h8000_0000;
		else
			return x[31:0];
	endfunction

	function automatic logic sat_q(input logic signed [33:0] x);
		return (x > 34'sd2147483647) || (x < -34'sd2147483648);
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] b;
		x = v;
		r = '0;
		b = 64'd1 << 62;
		for (int j = 0; j < 32; j++) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// 2^(2^-(i+1)) in Q1.30, each the floor square root of the one before.
	function automatic logic [30:0] exp_const(input int i);
		logic [63:0] c;
		c = 64'd2 << 30;
		for (int k = 0; k < 16; k++) begin
			if (k <= i)
				c = floor_sqrt(c << 30);
		end
		return c[30:0];
	endfunction

endpackage

// ===== hdl/pmsu_log2.sv =====
// Fixed-length log2 of the decayed gradient magnitude, one squaring per stage.
// Output is a signed Q6.16 logarithm plus the word's side payload.
// Depends on pmsu_pkg.
module pmsu_log2 import pmsu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               vld_i,
	input  side_t              side_i,
	input  logic signed [33:0] d_i,
	output logic               vld_o,
	output side_t              side_o,
	output logic signed [21:0] log_o
);

	logic        vld_s1;
	side_t       side_c;
	side_t       side_s1;
	logic [32:0] mag_s1;
	logic [5:0]  k_c;
	logic [30:0] norm_c;

	logic        v_s  [17];
	side_t       sd_s [17];
	logic [30:0] m_s  [17];
	logic [15:0] f_s  [17];
	logic [5:0]  k_s  [17];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			v_s[0] <= vld_s1;
		end
	end

	always_comb begin
		side_c      = side_i;
		side_c.neg  = d_i < 0;
		side_c.zero = d_i == 0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c;
			mag_s1  <= (d_i < 0) ? 33'(-d_i) : 33'(d_i);
		end
	end

	// Leading one and normalization to a Q1.30 mantissa in [1, 2).
	always_comb begin
		k_c = '0;
		for (int j = 0; j < 33; j++) begin
			if (mag_s1[j])
				k_c = 6'(j);
		end
		if (k_c > 6'd30)
			norm_c = 31'(mag_s1 >> (k_c - 6'd30));
		else
			norm_c = 31'({31'd0, mag_s1} << (6'd30 - k_c));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[0] <= side_s1;
			m_s[0]  <= norm_c;
			f_s[0]  <= '0;
			k_s[0]  <= k_c;
		end
	end

	for (genvar i = 0; i < 16; i++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] t;

		assign sq = m_s[i] * m_s[i];
		assign t  = sq[61:30];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		// A square of two or more yields the next fraction bit and is halved.
		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1] <= sd_s[i];
				m_s[i+1]  <= t[31] ? t[31:1] : t[30:0];
				f_s[i+1]  <= {f_s[i][14:0], t[31]};
				k_s[i+1]  <= k_s[i];
			end
		end
	end

	assign vld_o  = v_s[16];
	assign side_o = sd_s[16];
	assign log_o  = {6'(k_s[16] - 6'd16), f_s[16]};

endmodule

// ===== hdl/pmsu_exp2.sv =====
// Scales the logarithm by the exponent and takes exp2, one constant product per stage.
// Output is the signed powered gradient with its saturation flag in the side payload.
// Depends on pmsu_pkg.
module pmsu_exp2 import pmsu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cfg_t               cfg,
	input  logic               vld_i,
	input  side_t              side_i,
	input  logic signed [21:0] log_i,
	output logic               vld_o,
	output side_t              side_o,
	output logic signed [31:0] pow_o
);

	logic signed [38:0] prod;
	logic               vld_s1;
	side_t              side_s1;
	logic signed [30:0] y_s1;
	logic signed [14:0] n_c;

	logic               v_s   [17];
	side_t              sd_s  [17];
	logic [30:0]        r_s   [17];
	logic signed [14:0] n_s   [17];
	logic [15:0]        f_s   [17];
	logic               ovf_s [17];

	logic signed [15:0] sh_c;
	logic [30:0]        mag_c;
	side_t              side_c;
	logic               vld_q;
	side_t              side_q;
	logic signed [31:0] pow_q;

	assign prod = log_i * $signed({1'b0, cfg.expo});
	assign n_c  = y_s1[30:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			v_s[0] <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			v_s[0] <= vld_s1;
			vld_q  <= v_s[16];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1  <= side_i;
			y_s1     <= 31'(prod >>> 8);
			sd_s[0]  <= side_s1;
			r_s[0]   <= 31'd1 << 30;
			n_s[0]   <= n_c;
			f_s[0]   <= y_s1[15:0];
			ovf_s[0] <= n_c >= 15'sd15;
		end
	end

	for (genvar i = 0; i < 16; i++) begin : g_mul
		localparam logic [30:0] TC = exp_const(i);
		logic [61:0] pr;

		assign pr = r_s[i] * TC;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (en)
				v_s[i+1] <= v_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s[i+1]  <= sd_s[i];
				r_s[i+1]   <= f_s[i][15-i] ? pr[60:30] : r_s[i];
				n_s[i+1]   <= n_s[i];
				f_s[i+1]   <= f_s[i];
				ovf_s[i+1] <= ovf_s[i];
			end
		end
	end

	// Scale the Q1.30 fraction by 2^n down to Q16.16.
	always_comb begin
		sh_c = 16'sd14 - 16'(n_s[16]);
		if (ovf_s[16])
			mag_c = 31'h7FFF_FFFF;
		else if (n_s[16] >= 15'sd14)
			mag_c = r_s[16];
		else if (sh_c > 16'sd30)
			mag_c = '0;
		else
			mag_c = r_s[16] >> sh_c[4:0];
	end

	always_comb begin
		side_c     = sd_s[16];
		side_c.sat = ovf_s[16] && !sd_s[16].zero;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_c;
			if (sd_s[16].zero)
				pow_q <= '0;
			else if (sd_s[16].neg)
				pow_q <= -$signed({1'b0, mag_c});
			else
				pow_q <= $signed({1'b0, mag_c});
		end
	end

	assign vld_o  = vld_q;
	assign side_o = side_q;
	assign pow_o  = pow_q;

endmodule

// ===== hdl/pmsu_mom.sv =====
// Momentum store with read-modify-write, last-write forwarding and clearing after reset.
// Produces the clipped new momentum of each word.
// Depends on pmsu_pkg.
module pmsu_mom import pmsu_pkg::*; #(
	parameter int ELEMENTS = ELEMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  cfg_t               cfg,
	input  logic               vld_i,
	input  side_t              side_i,
	input  logic signed [31:0] pow_i,
	output logic               vld_o,
	output side_t              side_o,
	output logic signed [31:0] m_o,
	output logic               clearing
);

	localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

	logic signed [31:0] mem [ELEMENTS];

	logic [AW:0]        clr_cnt_q;
	logic [AW-1:0]      rd_addr;
	logic signed [31:0] rd_q;

	logic               vld_s1;
	side_t              side_s1;
	logic signed [31:0] pow_s1;
	logic [AW-1:0]      addr_s1;

	logic               lw_vld_q;
	logic [AW-1:0]      lw_addr_q;
	logic signed [31:0] lw_data_q;

	logic signed [31:0] m_old;
	logic signed [48:0] mprod;
	logic signed [33:0] msum;
	logic signed [31:0] m_new;
	side_t              side_c;

	logic               we;
	logic [AW-1:0]      wa;
	logic signed [31:0] wd;

	logic               vld_s2;
	side_t              side_s2;
	logic signed [31:0] m_s2;

	assign clearing = clr_cnt_q < (AW+1)'(ELEMENTS);
	assign addr_s1  = AW'(side_s1.idx);
	// While stalled the word in the modify stage re-reads its own entry.
	assign rd_addr  = en ? AW'(side_i.idx) : addr_s1;

	always_comb begin
		if (!side_s1.in_rng)
			m_old = '0;
		else if (lw_vld_q && lw_addr_q == addr_s1)
			m_old = lw_data_q;
		else
			m_old = rd_q;
		mprod = $signed({1'b0, cfg.mf}) * m_old;
		msum  = 34'(mprod >>> 16) + 34'(pow_s1);
		m_new = clip_q(msum);
		side_c     = side_s1;
		side_c.sat = side_s1.sat || sat_q(msum);
	end

	always_comb begin
		if (clearing) begin
			we = 1'b1;
			wa = clr_cnt_q[AW-1:0];
			wd = '0;
		end else begin
			we = en && vld_s1 && side_s1.in_rng;
			wa = addr_s1;
			wd = m_new;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			lw_vld_q  <= 1'b0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
		end else begin
			if (clearing)
				clr_cnt_q <= clr_cnt_q + 1'b1;
			if (we && !clearing)
				lw_vld_q <= 1'b1;
			if (en) begin
				vld_s1 <= vld_i;
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && !clearing) begin
			lw_addr_q <= wa;
			lw_data_q <= wd;
		end
		if (en) begin
			side_s1 <= side_i;
			pow_s1  <= pow_i;
			side_s2 <= side_c;
			m_s2    <= m_new;
		end
	end

	assign vld_o  = vld_s2;
	assign side_o = side_s2;
	assign m_o    = m_s2;

endmodule

// ===== hdl/power_momentum_sgd_update_core.sv =====
// Momentum SGD update core: one word in and one word out per clock while not stalled. An
// accepted input passes the 16 log2 squaring stages, the 16 exp2 product stages and the
// momentum read-modify-write stage on its way to the result. After reset the momentum memory
// is cleared one entry per cycle, ELEMENTS entries (4096 by default), while item_stall is
// high; configuration writes are taken throughout. A stalled result holds the pipeline.
module power_momentum_sgd_update_core import pmsu_pkg::*; #(
	parameter int ELEMENTS = ELEMENTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  in_t        item,
	output logic       result_valid,
	input  logic       result_stall,
	output out_t       result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  cfg_idx_t   cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t               cfg_q;
	logic               en;
	logic               accept;
	logic               clearing;

	logic signed [48:0] dprod;
	logic               vld_s1;
	side_t              side_s1;
	logic signed [33:0] d_s1;

	logic               lg_vld;
	side_t              lg_side;
	logic signed [21:0] lg_log;

	logic               ex_vld;
	side_t              ex_side;
	logic signed [31:0] ex_pow;

	logic               mm_vld;
	side_t              mm_side;
	logic signed [31:0] mm_m;

	logic signed [48:0] lprod;
	logic signed [33:0] pdiff;
	logic               result_valid_q;
	out_t               result_q;

	assign cfg_ready  = 1'b1;
	assign en         = !result_valid_q || !result_stall;
	assign item_stall = clearing || !en;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lr    <= LR_RST;
			cfg_q.mf    <= MF_RST;
			cfg_q.decay <= DECAY_RST;
			cfg_q.expo  <= EXPO_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_LR:    cfg_q.lr    <= cfg_data;
				CFG_MF:    cfg_q.mf    <= cfg_data;
				CFG_DECAY: cfg_q.decay <= cfg_data;
				CFG_EXPO:  cfg_q.expo  <= cfg_data;
				default:   cfg_q       <= cfg_q;
			endcase
		end
	end

	assign dprod = $signed({1'b0, cfg_q.decay}) * item.param_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1         <= accept;
			result_valid_q <= mm_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.idx    <= item.element_index;
			side_s1.p      <= item.param_value;
			side_s1.in_rng <= 32'(item.element_index) < 32'(ELEMENTS);
			side_s1.neg    <= 1'b0;
			side_s1.zero   <= 1'b0;
			side_s1.sat    <= 1'b0;
			d_s1           <= 34'(item.gradient_value) + 34'(dprod >>> 16);
		end
	end

	pmsu_log2 u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_s1),
		.side_i (side_s1),
		.d_i    (d_s1),
		.vld_o  (lg_vld),
		.side_o (lg_side),
		.log_o  (lg_log)
	);

	pmsu_exp2 u_exp2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg_q),
		.vld_i  (lg_vld),
		.side_i (lg_side),
		.log_i  (lg_log),
		.vld_o  (ex_vld),
		.side_o (ex_side),
		.pow_o  (ex_pow)
	);

	pmsu_mom #(
		.ELEMENTS (ELEMENTS)
	) u_mom (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.vld_i    (ex_vld),
		.side_i   (ex_side),
		.pow_i    (ex_pow),
		.vld_o    (mm_vld),
		.side_o   (mm_side),
		.m_o      (mm_m),
		.clearing (clearing)
	);

	assign lprod = $signed({1'b0, cfg_q.lr}) * mm_m;
	assign pdiff = 34'(mm_side.p) - 34'(lprod >>> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			result_q.out_index <= mm_side.idx;
			result_q.new_param <= clip_q(pdiff);
			result_q.saturated <= mm_side.sat || sat_q(pdiff);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Nothing can be in flight while the momentum memory is being cleared.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !result_valid && !vld_s1)
		else $error("word in flight during momentum clear");

	// An accepted word enters the first stage on the next edge.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> vld_s1)
		else $error("accepted word lost at pipeline entry");

	// A pending result freezes the pipeline, so the first stage holds its word.
	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(vld_s1) && $stable(d_s1))
		else $error("pipeline advanced while result stalled");
`endif

endmodule
